// ===== src/cfp_pkg.sv =====
// cfp_pkg: shared types, constants and the crc-8 update function of the
// framed command parser; no dependencies, imported by every module in src
`default_nettype none

package cfp_pkg;

  // payload store depth, its index and length widths, and the config index width
  localparam int MAX_PAYLOAD = 32;
  localparam int IDX_W       = 5;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT    = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0] HEADER_BYTE_RST = 8'hAA;
  localparam logic [7:0] CRC_POLY_RST    = 8'h07;
  localparam logic [7:0] CRC_INIT_RST    = 8'h00;

  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  // controller -> datapath
  typedef struct packed {
    logic ld_header;
    logic ld_command;
    logic ld_length;
    logic ld_data;
    logic rd_issue;
    logic out_load;
  } cfp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hdr_match;
    logic len_big;
    logic len_in_zero;
    logic len_zero;
    logic data_last;
    logic crc_ok;
    logic rd_last;
    logic out_free;
  } cfp_status_t;

  // msb-first, unreflected, no final xor
  function automatic logic [7:0] crc8_feed(input logic [7:0] acc,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = acc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== src/cfp_ctrl.sv =====
// cfp_ctrl: frame parsing and readout state machine of the parser
// depends on cfp_pkg for the command and status structs
`default_nettype none

module cfp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cfp_pkg::cfp_status_t sts,
  output cfp_pkg::cfp_cmd_t        cmd
);
  import cfp_pkg::*;

  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_COMMAND = 3'd1;
  localparam logic [2:0] ST_LENGTH  = 3'd2;
  localparam logic [2:0] ST_DATA    = 3'd3;
  localparam logic [2:0] ST_CRC     = 3'd4;
  localparam logic [2:0] ST_RD_ISS  = 3'd5;
  localparam logic [2:0] ST_RD_LOAD = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       take;

  assign in_ready = (state_r != ST_RD_ISS) && (state_r != ST_RD_LOAD);
  assign take     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_COMMAND: begin
        if (take) begin
          cmd.ld_command = 1'b1;
          state_nxt      = ST_LENGTH;
        end
      end
      ST_LENGTH: begin
        if (take) begin
          if (sts.len_big) begin
            state_nxt = ST_HEADER;
          end else begin
            cmd.ld_length = 1'b1;
            state_nxt     = sts.len_in_zero ? ST_CRC : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (take) begin
          cmd.ld_data = 1'b1;
          if (sts.data_last) begin
            state_nxt = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        if (take) begin
          state_nxt = ST_HEADER;
          if (sts.crc_ok) begin
            // empty frame needs no store read
            state_nxt = sts.len_zero ? ST_RD_LOAD : ST_RD_ISS;
          end
        end
      end
      ST_RD_ISS: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD_LOAD;
      end
      ST_RD_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = sts.rd_last ? ST_HEADER : ST_RD_ISS;
        end
      end
      default: begin
        // hunting for the header byte
        if (take) begin
          state_nxt = ST_HEADER;
          if (sts.hdr_match) begin
            cmd.ld_header = 1'b1;
            state_nxt     = ST_COMMAND;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/cfp_datapath.sv =====
// cfp_datapath: configuration registers, crc accumulator, frame fields,
// payload store and result register; depends on cfp_pkg
`default_nettype none

module cfp_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [cfp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [7:0]                           cfg_data,
  input  wire logic [7:0]                           in_rx_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [7:0]                                out_command_code,
  output logic [cfp_pkg::LEN_W-1:0]                 out_payload_length,
  output logic                                      out_has_payload,
  output logic [7:0]                                out_payload_byte,
  output logic [cfp_pkg::IDX_W-1:0]                 out_payload_index,
  output logic                                      out_last,
  input  wire cfp_pkg::cfp_cmd_t                    cmd,
  output cfp_pkg::cfp_status_t                      sts
);
  import cfp_pkg::*;

  logic [7:0]       header_r;
  logic [7:0]       poly_r;
  logic [7:0]       init_r;
  logic [7:0]       crc_r;
  logic [7:0]       command_r;
  logic [LEN_W-1:0] length_r;
  logic [LEN_W-1:0] count_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       store_r [MAX_PAYLOAD];
  logic             out_valid_r;
  logic [7:0]       crc_step;
  logic             length_zero;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r <= HEADER_BYTE_RST;
      poly_r   <= CRC_POLY_RST;
      init_r   <= CRC_INIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HEADER_BYTE: header_r <= cfg_data;
        REG_CRC_POLY:    poly_r   <= cfg_data;
        REG_CRC_INIT:    init_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // header starts from the init value, later bytes from the running crc
  assign crc_step = crc8_feed(cmd.ld_header ? init_r : crc_r, in_rx_byte, poly_r);

  assign length_zero = (length_r == '0);

  assign sts.hdr_match   = (in_rx_byte == header_r);
  assign sts.len_big     = (in_rx_byte > MAX_PAYLOAD_B);
  assign sts.len_in_zero = (in_rx_byte == 8'd0);
  assign sts.len_zero    = length_zero;
  assign sts.data_last   = ((count_r + LEN_W'(1)) >= length_r);
  assign sts.crc_ok      = (crc_r == in_rx_byte);
  assign sts.rd_last     = length_zero || ({1'b0, rd_idx_r} + LEN_W'(1) == length_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.ld_header || cmd.ld_command || cmd.ld_length || cmd.ld_data) begin
      crc_r <= crc_step;
    end
    if (cmd.ld_command) begin
      command_r <= in_rx_byte;
    end
    if (cmd.ld_length) begin
      length_r <= in_rx_byte[LEN_W-1:0];
      count_r  <= '0;
      rd_idx_r <= '0;
    end
    if (cmd.ld_data) begin
      count_r <= count_r + LEN_W'(1);
    end
    if (cmd.out_load) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.ld_data) begin
      store_r[count_r[IDX_W-1:0]] <= in_rx_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= store_r[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_command_code   <= command_r;
      out_payload_length <= length_r;
      out_has_payload    <= !length_zero;
      out_payload_byte   <= length_zero ? 8'd0 : rd_data_r;
      out_payload_index  <= length_zero ? '0 : rd_idx_r;
      out_last           <= sts.rd_last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== src/crc8_framed_command_parser_top.sv =====
// crc8_framed_command_parser_top: top level of the framed command parser
// joins cfp_ctrl and cfp_datapath; depends on cfp_pkg
//
// usage: received bytes enter on in_rx_byte with in_valid/in_ready, one byte
// per request. frames are header, command, length, payload, crc-8. after a
// frame whose crc byte matches, the block drives one result per payload byte
// (one result for an empty frame) on the out_ channel, out_last on the final
// one. bad crc or an oversized length drops the frame with no result.
// in_ready is high in every parsing state. after the crc byte, in_ready
// is low during readout: each payload result takes a store read, then a load
// of the result register; an empty frame's result takes only the load.
// a stalled receiver holds the result register and readout waits; parsing
// resumes after the last result loads.
// configuration writes (cfg_index 0 header, 1 polynomial, 2 init value) are
// always ready; index 3 is ignored.
// reset (rst_n low, synchronous) restores header 0xaa, polynomial 0x07,
// init 0x00, empties the result register and hunts for the header.
`default_nettype none

module crc8_framed_command_parser_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [7:0]                         out_command_code,
  output logic [cfp_pkg::LEN_W-1:0]          out_payload_length,
  output logic                               out_has_payload,
  output logic [7:0]                         out_payload_byte,
  output logic [cfp_pkg::IDX_W-1:0]          out_payload_index,
  output logic                               out_last
);
  import cfp_pkg::*;

  cfp_cmd_t    cmd;
  cfp_status_t sts;

  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfp_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command_code   (out_command_code),
    .out_payload_length (out_payload_length),
    .out_has_payload    (out_has_payload),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_last           (out_last),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench for crc8_framed_command_parser_top: sends framed and broken byte
// streams, predicts the accepted frames and checks every result; uses cfp_pkg

module testbench;
  import cfp_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } parse_phase_t;

  typedef struct packed {
    logic [7:0]       command_code;
    logic [LEN_W-1:0] payload_length;
    logic             has_payload;
    logic [7:0]       payload_byte;
    logic [IDX_W-1:0] payload_index;
    logic             last;
  } frame_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_command_code;
  logic [LEN_W-1:0]     out_payload_length;
  logic                 out_has_payload;
  logic [7:0]           out_payload_byte;
  logic [IDX_W-1:0]     out_payload_index;
  logic                 out_last;

  crc8_framed_command_parser_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_command_code   (out_command_code),
    .out_payload_length (out_payload_length),
    .out_has_payload    (out_has_payload),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_last           (out_last)
  );

  // parser model state and its copy of the registers
  logic [7:0]   hdr_cfg;
  logic [7:0]   poly_cfg;
  logic [7:0]   init_cfg;
  parse_phase_t phase;
  logic [7:0]   cmd_r;
  logic [7:0]   len_r;
  int           data_cnt;
  logic [7:0]   crc_acc;
  logic [7:0]   payload_mem [0:MAX_PAYLOAD-1];

  frame_result_t pending_results[$];
  frame_result_t observed;
  frame_result_t wanted;
  logic [7:0]    tx_payload [0:MAX_PAYLOAD-1];

  int  errors;
  int  bytes_in;
  int  frames_ok;
  int  results_checked;
  int  reg_writes;
  bit  no_idle;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ poly_cfg) : (r << 1);
    return r;
  endfunction

  task automatic reset_parser_model();
    hdr_cfg  = HEADER_BYTE_RST;
    poly_cfg = CRC_POLY_RST;
    init_cfg = CRC_INIT_RST;
    phase    = PH_HUNT;
    cmd_r    = '0;
    len_r    = '0;
    data_cnt = 0;
    crc_acc  = CRC_INIT_RST;
    for (int i = 0; i < MAX_PAYLOAD; i++) payload_mem[i] = '0;
  endtask

  // advance the parser model by one received byte, queue the results of any frame that passes crc
  task automatic parse_byte(input logic [7:0] b);
    frame_result_t r;
    case (phase)
      PH_CMD: begin
        cmd_r   = b;
        crc_acc = crc8_step(crc_acc, b);
        phase   = PH_LEN;
      end
      PH_LEN: begin
        len_r = b;
        if (b > MAX_PAYLOAD_B) begin
          phase = PH_HUNT;
        end else begin
          crc_acc  = crc8_step(crc_acc, b);
          data_cnt = 0;
          phase    = (b == 8'd0) ? PH_CRC : PH_DATA;
        end
      end
      PH_DATA: begin
        payload_mem[data_cnt] = b;
        crc_acc  = crc8_step(crc_acc, b);
        data_cnt++;
        if (data_cnt >= len_r) phase = PH_CRC;
      end
      PH_CRC: begin
        if (crc_acc == b) begin
          frames_ok++;
          if (len_r == 8'd0) begin
            r = '{command_code: cmd_r, payload_length: '0, has_payload: 1'b0,
                  payload_byte: '0, payload_index: '0, last: 1'b1};
            pending_results.push_back(r);
          end else begin
            for (int i = 0; i < len_r; i++) begin
              r = '{command_code: cmd_r, payload_length: len_r[LEN_W-1:0],
                    has_payload: 1'b1, payload_byte: payload_mem[i],
                    payload_index: i[IDX_W-1:0], last: (i + 1 == len_r)};
              pending_results.push_back(r);
            end
          end
        end
        phase = PH_HUNT;
      end
      default: begin
        if (b == hdr_cfg) begin
          crc_acc = crc8_step(init_cfg, b);
          phase   = PH_CMD;
        end
      end
    endcase
  endtask

  // one byte request; valid stays up after acceptance until the caller moves on
  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_in++;
    parse_byte(b);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    while (!no_idle && $urandom_range(99) < 29) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      REG_HEADER_BYTE: hdr_cfg  = val;
      REG_CRC_POLY:    poly_cfg = val;
      REG_CRC_INIT:    init_cfg = val;
      default: ;
    endcase
  endtask

  // stop sending, wait for all pending results, then a few quiet cycles
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // push the parser back to header hunting without producing a frame
  task automatic close_open_frame();
    while (phase != PH_HUNT) begin
      case (phase)
        PH_CMD:  send_byte(8'h00);
        PH_LEN:  send_byte(8'hFF);
        PH_DATA: send_byte(8'($urandom));
        default: send_byte(crc_acc ^ 8'h01);
      endcase
    end
  endtask

  // header, command, length, payload from tx_payload, then a good or bad crc
  task automatic drive_frame(input logic [7:0] cmd, input int len, input bit good_crc);
    send_byte(hdr_cfg);
    send_byte(cmd);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) send_byte(tx_payload[i]);
    send_byte(good_crc ? crc_acc : crc_acc ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic fill_random_payload();
    for (int i = 0; i < MAX_PAYLOAD; i++) tx_payload[i] = 8'($urandom);
  endtask

  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 29);
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      observed = '{command_code: out_command_code, payload_length: out_payload_length,
                   has_payload: out_has_payload, payload_byte: out_payload_byte,
                   payload_index: out_payload_index, last: out_last};
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: cmd=%h len=%0d has=%b byte=%h idx=%0d last=%b",
                   observed.command_code, observed.payload_length, observed.has_payload,
                   observed.payload_byte, observed.payload_index, observed.last);
      end else begin
        wanted = pending_results.pop_front();
        results_checked++;
        if (observed.command_code !== wanted.command_code ||
            observed.payload_length !== wanted.payload_length ||
            observed.has_payload !== wanted.has_payload ||
            observed.payload_byte !== wanted.payload_byte ||
            observed.payload_index !== wanted.payload_index ||
            observed.last !== wanted.last) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: exp cmd=%h len=%0d has=%b byte=%h idx=%0d last=%b",
                     wanted.command_code, wanted.payload_length, wanted.has_payload,
                     wanted.payload_byte, wanted.payload_index, wanted.last);
            $display("          got cmd=%h len=%0d has=%b byte=%h idx=%0d last=%b",
                     observed.command_code, observed.payload_length,
                     observed.has_payload, observed.payload_byte,
                     observed.payload_index, observed.last);
          end
        end
      end
    end
  end

  task automatic test_empty_frame();
    drive_frame(8'hFF, 0, 1'b1);
  endtask

  task automatic test_length_too_large();
    send_byte(hdr_cfg);
    send_byte(8'h01);
    send_byte(8'(MAX_PAYLOAD + 1));
    send_byte(hdr_cfg);
    send_byte(8'h80);
    send_byte(8'hFF);
  endtask

  task automatic test_crc_mismatch();
    tx_payload[0] = 8'h00;
    drive_frame(8'h00, 1, 1'b0);
  endtask

  // extreme register values, an ignored index, and writes in the middle of a frame
  task automatic test_register_writes();
    settle();
    cfg_write(REG_HEADER_BYTE, 8'hFF);
    cfg_write(REG_CRC_POLY, 8'hFF);
    cfg_write(REG_CRC_INIT, 8'hFF);
    cfg_write(REG_UNUSED, 8'h00);
    cfg_valid <= 1'b0;
    send_byte(hdr_cfg);
    send_byte(8'h3C);
    settle();
    // new polynomial applies to the rest of this frame, new init only to the next one
    cfg_write(REG_CRC_POLY, 8'h00);
    cfg_write(REG_CRC_INIT, 8'h5A);
    cfg_valid <= 1'b0;
    send_byte(8'd1);
    send_byte(8'hFF);
    send_byte(crc_acc);
  endtask

  task automatic random_round(input logic [7:0] hdr, input logic [7:0] poly,
                              input logic [7:0] init, input int nbytes,
                              input bit full_frame, input bit quiet);
    int         stop_at;
    int         pick;
    int         len;
    logic [7:0] cmd;
    close_open_frame();
    settle();
    cfg_write(REG_HEADER_BYTE, hdr);
    cfg_write(REG_CRC_POLY, poly);
    cfg_write(REG_CRC_INIT, init);
    cfg_valid <= 1'b0;
    no_idle = quiet;
    stop_at = bytes_in + nbytes;
    if (full_frame) begin
      fill_random_payload();
      drive_frame(8'($urandom), MAX_PAYLOAD, 1'b1);
    end
    while (bytes_in < stop_at) begin
      pick = $urandom_range(99);
      cmd  = 8'($urandom);
      len  = ($urandom_range(9) == 0) ? $urandom_range(7, MAX_PAYLOAD) : $urandom_range(0, 6);
      fill_random_payload();
      if (pick < 70) begin
        drive_frame(cmd, len, 1'b1);
      end else if (pick < 80) begin
        drive_frame(cmd, len, 1'b0);
      end else if (pick < 88) begin
        send_byte(hdr_cfg);
        send_byte(cmd);
        send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
      end else if (pick < 94) begin
        // frame cut short, the next bytes land in the wrong fields
        send_byte(hdr_cfg);
        send_byte(cmd);
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    random_round(8'($urandom), 8'($urandom), 8'($urandom), 45, 1'b0, 1'b0);
    random_round(8'hFF, 8'hFF, 8'hFF, 45, 1'b1, 1'b0);
    random_round(8'h00, 8'h00, 8'h00, 45, 1'b1, 1'b1);
    random_round(HEADER_BYTE_RST, CRC_POLY_RST, CRC_INIT_RST, 45, 1'b0, 1'b0);
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_HEADER_BYTE;
    cfg_data   = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_ready  = 1'b0;
    errors          = 0;
    bytes_in        = 0;
    frames_ok       = 0;
    results_checked = 0;
    reg_writes      = 0;
    no_idle         = 1'b0;
    reset_parser_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_frame();
    test_length_too_large();
    test_crc_mismatch();
    test_register_writes();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes with %0d register writes over five register settings",
             bytes_in, reg_writes);
    $display("%0d frames passed crc, %0d results checked, %0d errors",
             frames_ok, results_checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cfp_pkg.sv
src/cfp_ctrl.sv
src/cfp_datapath.sv
src/crc8_framed_command_parser_top.sv
sim/testbench.sv
